### rtl/jsps_pkg.sv
`timescale 1ns / 1ps

package jsps_pkg;

  // Default store dimensions.
  localparam int MAX_WIDTH_DEFAULT  = 256;
  localparam int MAX_HEIGHT_DEFAULT = 256;

  // Field widths fixed by the item formats.
  localparam int COL_W       = 8;
  localparam int ROW_W       = 8;
  localparam int VAL_W       = 16;
  localparam int DIM_W       = 9;
  localparam int COUPLING_W  = 24;
  localparam int INV_W       = 16;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_INDEX_W = 3;
  localparam int CELL_W      = 2 * VAL_W;

  // Register reset values.
  localparam logic [DIM_W-1:0]      GRID_WIDTH_RESET  = 9'd256;
  localparam logic [DIM_W-1:0]      GRID_HEIGHT_RESET = 9'd256;
  localparam logic [COUPLING_W-1:0] COUPLING_RESET    = 24'd41943;
  localparam logic [INV_W-1:0]      INV_DENOM_RESET   = 16'd100;

  // Item kinds.
  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_COMPUTE = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_GRID_WIDTH  = 3'd0,
    REG_GRID_HEIGHT = 3'd1,
    REG_COUPLING    = 3'd2,
    REG_INV_DENOM   = 3'd3,
    REG_CLEAR       = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_LEFT,
    S_RD_RIGHT,
    S_RD_DOWN,
    S_RD_UP,
    S_ACC,
    S_MUL1,
    S_MUL2,
    S_FINISH
  } state_t;

  typedef enum logic [2:0] {
    ADDR_ITEM,
    ADDR_LEFT,
    ADDR_RIGHT,
    ADDR_DOWN,
    ADDR_UP
  } addr_sel_t;

  typedef struct packed {
    logic                    mode;
    logic [COL_W-1:0]        col;
    logic [ROW_W-1:0]        row;
    logic signed [VAL_W-1:0] stream_in;
    logic signed [VAL_W-1:0] vorticity_in;
  } item_t;

  typedef struct packed {
    logic [COL_W-1:0]        col_out;
    logic [ROW_W-1:0]        row_out;
    logic signed [VAL_W-1:0] stream_out;
    logic                    saturated;
  } result_t;

  typedef struct packed {
    logic      load_we;
    logic      capture;
    logic      rd_en;
    addr_sel_t rd_sel;
    logic      vort_en;
    logic      sum_first;
    logic      sum_en;
    logic      mul1_en;
    logic      mul2_en;
    logic      out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_grid;
    logic load_ok;
    logic out_busy;
  } ctrl_status_t;

endpackage

### rtl/jsps_if.sv
`timescale 1ns / 1ps

interface jsps_item_if;
  logic             valid;
  logic             ready;
  jsps_pkg::item_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface jsps_result_if;
  logic              valid;
  logic              ready;
  jsps_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/jsps_ram.sv
`timescale 1ns / 1ps

module jsps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

### rtl/jsps_datapath.sv
`timescale 1ns / 1ps

module jsps_datapath #(
  parameter int MAX_WIDTH  = jsps_pkg::MAX_WIDTH_DEFAULT,
  parameter int MAX_HEIGHT = jsps_pkg::MAX_HEIGHT_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [jsps_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [jsps_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  jsps_pkg::item_t                    item_data,
  input  jsps_pkg::ctrl_cmd_t                cmd,
  output jsps_pkg::ctrl_status_t             status,
  jsps_result_if.source                      result
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int ADDR_W = CW + RW;
  localparam int DEPTH  = 2 ** ADDR_W;
  localparam int DW     = jsps_pkg::DIM_W;

  localparam logic signed [61:0] ROUND_HALF = 62'sh800000;
  localparam logic signed [37:0] Q_MAX      = 38'sd32767;
  localparam logic signed [37:0] Q_MIN      = -38'sd32768;

  // Configuration registers.
  logic [DW-1:0]                       grid_width;
  logic [DW-1:0]                       grid_height;
  logic [jsps_pkg::COUPLING_W-1:0]     coupling;
  logic [jsps_pkg::INV_W-1:0]          inv_denom;
  logic                                clear_output;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width   <= jsps_pkg::GRID_WIDTH_RESET;
      grid_height  <= jsps_pkg::GRID_HEIGHT_RESET;
      coupling     <= jsps_pkg::COUPLING_RESET;
      inv_denom    <= jsps_pkg::INV_DENOM_RESET;
      clear_output <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        jsps_pkg::REG_GRID_WIDTH:  grid_width   <= cfg_data[DW-1:0];
        jsps_pkg::REG_GRID_HEIGHT: grid_height  <= cfg_data[DW-1:0];
        jsps_pkg::REG_COUPLING:    coupling     <= cfg_data[jsps_pkg::COUPLING_W-1:0];
        jsps_pkg::REG_INV_DENOM:   inv_denom    <= cfg_data[jsps_pkg::INV_W-1:0];
        jsps_pkg::REG_CLEAR:       clear_output <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Effective grid size, forced into one up to the store dimension.
  logic [DW-1:0] eff_w;
  logic [DW-1:0] eff_h;

  always_comb begin
    if (grid_width == '0) begin
      eff_w = DW'(1);
    end else if (int'(grid_width) > MAX_WIDTH) begin
      eff_w = DW'(MAX_WIDTH);
    end else begin
      eff_w = grid_width;
    end
    if (grid_height == '0) begin
      eff_h = DW'(1);
    end else if (int'(grid_height) > MAX_HEIGHT) begin
      eff_h = DW'(MAX_HEIGHT);
    end else begin
      eff_h = grid_height;
    end
  end

  assign status.in_grid  = ({1'b0, item_data.col} < eff_w) && ({1'b0, item_data.row} < eff_h);
  assign status.load_ok  = (int'(item_data.col) < MAX_WIDTH) &&
                           (int'(item_data.row) < MAX_HEIGHT);
  assign status.out_busy = result.valid && !result.ready;

  // Cell being computed.
  logic [jsps_pkg::COL_W-1:0] cur_col;
  logic [jsps_pkg::ROW_W-1:0] cur_row;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_col <= item_data.col;
      cur_row <= item_data.row;
    end
  end

  // Periodic neighbour indexes.
  logic [DW-1:0] col9, row9, left9, right9, down9, up9;

  always_comb begin
    col9   = {1'b0, cur_col};
    row9   = {1'b0, cur_row};
    left9  = (cur_col == '0) ? eff_w - DW'(1) : col9 - DW'(1);
    right9 = (col9 == eff_w - DW'(1)) ? '0 : col9 + DW'(1);
    down9  = (cur_row == '0) ? eff_h - DW'(1) : row9 - DW'(1);
    up9    = (row9 == eff_h - DW'(1)) ? '0 : row9 + DW'(1);
  end

  logic [ADDR_W-1:0] addr;

  always_comb begin
    case (cmd.rd_sel)
      jsps_pkg::ADDR_ITEM:  addr = {RW'(item_data.row), CW'(item_data.col)};
      jsps_pkg::ADDR_LEFT:  addr = {RW'(cur_row), CW'(left9)};
      jsps_pkg::ADDR_RIGHT: addr = {RW'(cur_row), CW'(right9)};
      jsps_pkg::ADDR_DOWN:  addr = {RW'(down9), CW'(cur_col)};
      jsps_pkg::ADDR_UP:    addr = {RW'(up9), CW'(cur_col)};
      default:              addr = {RW'(item_data.row), CW'(item_data.col)};
    endcase
  end

  logic [jsps_pkg::CELL_W-1:0] rdata;

  jsps_ram #(
    .WIDTH (jsps_pkg::CELL_W),
    .DEPTH (DEPTH)
  ) u_cells (
    .clk   (clk),
    .en    (cmd.load_we || cmd.rd_en),
    .we    (cmd.load_we),
    .addr  (addr),
    .wdata ({item_data.vorticity_in, item_data.stream_in}),
    .rdata (rdata)
  );

  // Arithmetic chain: neighbour sum, times coupling, minus scaled vorticity,
  // times the reciprocal, then round and saturate.
  logic signed [15:0] rd_stream;
  logic signed [15:0] vort;
  logic signed [17:0] sum;
  logic signed [24:0] coupling_s;
  logic signed [16:0] inv_s;
  logic signed [42:0] prod1;
  logic signed [23:0] vort_scaled;
  logic signed [43:0] diff;
  logic signed [60:0] prod2;
  logic signed [61:0] x_round;
  logic signed [37:0] q;

  assign rd_stream   = rdata[15:0];
  assign coupling_s  = {1'b0, coupling};
  assign inv_s       = {1'b0, inv_denom};
  assign vort_scaled = {vort, 8'h00};
  assign diff        = 44'(prod1) - 44'(vort_scaled);
  assign x_round     = 62'(prod2) + ROUND_HALF;
  assign q           = 38'(x_round >>> 24);

  always_ff @(posedge clk) begin
    if (cmd.vort_en) begin
      vort <= rdata[31:16];
    end
    if (cmd.sum_first) begin
      sum <= 18'(rd_stream);
    end else if (cmd.sum_en) begin
      sum <= sum + 18'(rd_stream);
    end
    if (cmd.mul1_en) begin
      prod1 <= sum * coupling_s;
    end
    if (cmd.mul2_en) begin
      prod2 <= diff * inv_s;
    end
  end

  jsps_pkg::result_t res_next;

  always_comb begin
    res_next.col_out = cur_col;
    res_next.row_out = cur_row;
    if (clear_output) begin
      res_next.stream_out = '0;
      res_next.saturated  = 1'b0;
    end else if (q > Q_MAX) begin
      res_next.stream_out = 16'sh7FFF;
      res_next.saturated  = 1'b1;
    end else if (q < Q_MIN) begin
      res_next.stream_out = 16'sh8000;
      res_next.saturated  = 1'b1;
    end else begin
      res_next.stream_out = q[15:0];
      res_next.saturated  = 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (cmd.out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.data <= res_next;
    end
  end

endmodule

### rtl/jsps_ctrl.sv
`timescale 1ns / 1ps

module jsps_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  input  logic                   item_mode,
  output logic                   item_ready,
  input  jsps_pkg::ctrl_status_t status,
  output jsps_pkg::ctrl_cmd_t    cmd
);

  jsps_pkg::state_t state;
  jsps_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jsps_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      jsps_pkg::S_IDLE: begin
        if (item_valid && item_mode == jsps_pkg::MODE_COMPUTE && status.in_grid) begin
          state_next = jsps_pkg::S_RD_LEFT;
        end
      end
      jsps_pkg::S_RD_LEFT:  state_next = jsps_pkg::S_RD_RIGHT;
      jsps_pkg::S_RD_RIGHT: state_next = jsps_pkg::S_RD_DOWN;
      jsps_pkg::S_RD_DOWN:  state_next = jsps_pkg::S_RD_UP;
      jsps_pkg::S_RD_UP:    state_next = jsps_pkg::S_ACC;
      jsps_pkg::S_ACC:      state_next = jsps_pkg::S_MUL1;
      jsps_pkg::S_MUL1:     state_next = jsps_pkg::S_MUL2;
      jsps_pkg::S_MUL2:     state_next = jsps_pkg::S_FINISH;
      jsps_pkg::S_FINISH: begin
        if (!status.out_busy) begin
          state_next = jsps_pkg::S_IDLE;
        end
      end
      default: state_next = jsps_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = jsps_pkg::ADDR_ITEM;
    item_ready = 1'b0;
    case (state)
      jsps_pkg::S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          if (item_mode == jsps_pkg::MODE_LOAD) begin
            cmd.load_we = status.load_ok;
          end else if (status.in_grid) begin
            cmd.capture = 1'b1;
            cmd.rd_en   = 1'b1;
          end
        end
      end
      jsps_pkg::S_RD_LEFT: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = jsps_pkg::ADDR_LEFT;
        cmd.vort_en = 1'b1;
      end
      jsps_pkg::S_RD_RIGHT: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_sel    = jsps_pkg::ADDR_RIGHT;
        cmd.sum_first = 1'b1;
      end
      jsps_pkg::S_RD_DOWN: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = jsps_pkg::ADDR_DOWN;
        cmd.sum_en = 1'b1;
      end
      jsps_pkg::S_RD_UP: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = jsps_pkg::ADDR_UP;
        cmd.sum_en = 1'b1;
      end
      jsps_pkg::S_ACC:    cmd.sum_en   = 1'b1;
      jsps_pkg::S_MUL1:   cmd.mul1_en  = 1'b1;
      jsps_pkg::S_MUL2:   cmd.mul2_en  = 1'b1;
      jsps_pkg::S_FINISH: cmd.out_load = !status.out_busy;
      default: begin
      end
    endcase
  end

`ifndef SYNTH
  a_compute_starts: assert property (@(posedge clk) disable iff (rst)
    (state == jsps_pkg::S_IDLE && item_valid && item_mode == jsps_pkg::MODE_COMPUTE &&
     status.in_grid) |=> state == jsps_pkg::S_RD_LEFT)
    else $error("accepted compute item did not start the neighbour reads");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !status.out_busy)
    else $error("result register loaded while a result was still waiting");

  a_finish_holds: assert property (@(posedge clk) disable iff (rst)
    (state == jsps_pkg::S_FINISH && !cmd.out_load) |=> state == jsps_pkg::S_FINISH)
    else $error("finished result dropped before it was registered");

  a_write_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load_we |-> (state == jsps_pkg::S_IDLE && !cmd.rd_en))
    else $error("cell store written during a compute");
`endif

endmodule

### rtl/jacobi_stream_poisson_stencil_top.sv
`timescale 1ns / 1ps

// Five-point periodic Jacobi sweep over a stored grid of stream-function and
// vorticity cells, one cell per compute item.
// Channels: item (sink) carries load and compute beats; result (source) carries
// one beat per compute beat whose cell lies inside the active grid. Both use
// valid/ready, and a beat moves on a clock edge where both are high.
// The cfg_write/cfg_index/cfg_data port writes the five registers; write them
// only while no compute beat is in flight.
// A load beat writes the cell store directly if its cell lies inside the store and
// is dropped otherwise. A compute beat outside the grid is taken and gives nothing.
// A compute beat inside the grid holds item ready low while it is worked on, and
// the next beat can be taken at the end of the first cycle its result is valid,
// so no new compute beat is taken before the last result is registered. The steps
// are five reads through the single port of the cell store, a last accumulate,
// two registered multiplies and a round-and-saturate stage.
// The result sits in an output register, so a new beat is taken while the
// previous result waits. If the receiver stalls, the block stops in its last
// stage with the next result until the output register frees up.
// Reset (rst, synchronous) returns the controller to idle, empties the output
// register and restores register defaults. The cell store is not cleared:
// a cell must be loaded before any compute beat reads it.
module jacobi_stream_poisson_stencil_top #(
  parameter int MAX_WIDTH  = jsps_pkg::MAX_WIDTH_DEFAULT,
  parameter int MAX_HEIGHT = jsps_pkg::MAX_HEIGHT_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  jsps_item_if.sink                        item,
  jsps_result_if.source                    result,
  input  logic                             cfg_write,
  input  logic [jsps_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [jsps_pkg::CFG_DATA_W-1:0]  cfg_data
);

  jsps_pkg::ctrl_cmd_t    cmd;
  jsps_pkg::ctrl_status_t status;
  logic                   item_ready;

  assign item.ready = item_ready;

  jsps_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_mode  (item.data.mode),
    .item_ready (item_ready),
    .status     (status),
    .cmd        (cmd)
  );

  jsps_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item_data (item.data),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

endmodule
